// ===== rtl/core/pbit_pkg.sv =====
// Shared constants, codes and types of the packet buffer id table.
`timescale 1ns / 1ps

package pbit_pkg;

    localparam int SLOT_BITS  = 8;
    localparam int SLOT_COUNT = 1 << SLOT_BITS;
    localparam int ID_W       = 32;
    localparam int COOKIE_W   = ID_W - SLOT_BITS;
    localparam int TIME_W     = 48;
    localparam int HANDLE_W   = 32;
    localparam int PORT_W     = 16;
    localparam int HOLD_W     = 16;

    localparam logic [HOLD_W-1:0]   HOLD_RESET  = HOLD_W'(5000);
    localparam logic [COOKIE_W-1:0] COOKIE_LAST = '1;
    localparam logic [ID_W-1:0]     REFUSED_ID  = '1;
    localparam logic [PORT_W-1:0]   NO_PORT     = '1;
    localparam logic [TIME_W-1:0]   TIME_MAX    = '1;

    typedef enum logic [1:0] {
        CMD_SAVE     = 2'd0,
        CMD_RETRIEVE = 2'd1,
        CMD_DISCARD  = 2'd2,
        CMD_NOP      = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_BUSY     = 2'd1,
        ST_EMPTY    = 2'd2,
        ST_MISMATCH = 2'd3
    } status_t;

    typedef struct packed {
        logic [COOKIE_W-1:0] cookie;
        logic [TIME_W-1:0]   deadline;
        logic [HANDLE_W-1:0] handle;
        logic [PORT_W-1:0]   port;
    } slot_entry_t;

    typedef struct packed {
        status_t             status;
        logic [ID_W-1:0]     buffer_id;
        logic [HANDLE_W-1:0] out_handle;
        logic [PORT_W-1:0]   out_port;
        logic                freed_valid;
        logic [HANDLE_W-1:0] freed_handle;
    } result_t;

endpackage

// ===== rtl/core/packet_buffer_id_table.sv =====
// Packet buffer id table: slot ring with generation cookies and hold deadlines.
// The slot RAM is read when a word is accepted; the result is registered in S_EXEC once
// the output register is free. No new word is taken while a word is in S_EXEC.
// A waiting result is held in the output register; the next word is still taken.
// Reset: all slots empty with cookie 0, next slot 0, hold time 5000 ms; no clearing pass.
`timescale 1ns / 1ps

module packet_buffer_id_table
    import pbit_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,

    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [HOLD_W-1:0]   cfg_data,

    input  logic                in_valid,
    output logic                in_stall,
    input  logic [1:0]          command,
    input  logic [HANDLE_W-1:0] buffer_handle,
    input  logic [PORT_W-1:0]   arrival_port,
    input  logic [ID_W-1:0]     request_id,
    input  logic [TIME_W-1:0]   now_ms,

    output logic                out_valid,
    input  logic                out_stall,
    output logic [1:0]          status,
    output logic [ID_W-1:0]     buffer_id,
    output logic [HANDLE_W-1:0] out_handle,
    output logic [PORT_W-1:0]   out_port,
    output logic                freed_valid,
    output logic [HANDLE_W-1:0] freed_handle
);

    typedef enum logic {
        S_IDLE,
        S_EXEC
    } state_t;

    state_t                 state_reg, state_next;
    logic [HOLD_W-1:0]      hold_reg;
    logic [SLOT_BITS-1:0]   next_slot_reg, next_slot_next;
    logic [SLOT_COUNT-1:0]  full_reg, full_next;
    logic [SLOT_COUNT-1:0]  used_reg, used_next;
    logic                   out_valid_reg, out_valid_next;
    result_t                res_reg, res_next;

    // latched request
    cmd_t                   cmd_reg;
    logic [SLOT_BITS-1:0]   slot_reg;
    logic [COOKIE_W-1:0]    req_cookie_reg;
    logic [HANDLE_W-1:0]    handle_reg;
    logic [PORT_W-1:0]      port_reg;
    logic [TIME_W-1:0]      now_reg;

    logic                   accept;
    logic                   finish;
    logic [SLOT_BITS-1:0]   rd_slot;
    slot_entry_t            rd_entry;
    slot_entry_t            wr_entry;
    logic                   wr_en;
    logic                   slot_is_full;
    logic [COOKIE_W-1:0]    cur_cookie;
    logic [COOKIE_W-1:0]    bumped;
    logic [TIME_W:0]        dl_sum;
    logic [TIME_W-1:0]      dl_sat;

    assign cfg_ready = 1'b1;
    assign in_stall  = (state_reg == S_EXEC);
    assign accept    = in_valid && !in_stall;
    assign finish    = (state_reg == S_EXEC) && (!out_valid_reg || !out_stall);
    assign rd_slot   = (cmd_t'(command) == CMD_SAVE) ? next_slot_reg
                                                     : request_id[SLOT_BITS-1:0];

    pbit_ram #(
        .WIDTH ($bits(slot_entry_t)),
        .DEPTH (SLOT_COUNT)
    ) u_slot_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (slot_reg),
        .wr_data (wr_entry),
        .rd_en   (accept),
        .rd_addr (rd_slot),
        .rd_data (rd_entry)
    );

    // never-written slots read as cookie 0
    assign slot_is_full = full_reg[slot_reg];
    assign cur_cookie   = used_reg[slot_reg] ? rd_entry.cookie : '0;

    always_comb
    begin
        bumped = cur_cookie + COOKIE_W'(1);
        if (bumped == COOKIE_LAST)
        begin
            bumped = '0;
        end
    end

    assign dl_sum = {1'b0, now_reg} + {{(TIME_W + 1 - HOLD_W){1'b0}}, hold_reg};
    assign dl_sat = dl_sum[TIME_W] ? TIME_MAX : dl_sum[TIME_W-1:0];

    assign wr_entry.cookie   = bumped;
    assign wr_entry.deadline = dl_sat;
    assign wr_entry.handle   = handle_reg;
    assign wr_entry.port     = port_reg;

    always_comb
    begin
        state_next     = state_reg;
        next_slot_next = next_slot_reg;
        full_next      = full_reg;
        used_next      = used_reg;
        out_valid_next = out_valid_reg;
        res_next       = res_reg;
        wr_en          = 1'b0;

        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end

        if (accept)
        begin
            state_next = S_EXEC;
            if (cmd_t'(command) == CMD_SAVE)
            begin
                next_slot_next = next_slot_reg + SLOT_BITS'(1);
            end
        end

        if (finish)
        begin
            state_next     = S_IDLE;
            out_valid_next = 1'b1;
            res_next       = '0;
            unique case (cmd_reg)
                CMD_SAVE:
                begin
                    if (slot_is_full && (now_reg < rd_entry.deadline))
                    begin
                        res_next.status    = ST_BUSY;
                        res_next.buffer_id = REFUSED_ID;
                    end
                    else
                    begin
                        res_next.freed_valid  = slot_is_full;
                        res_next.freed_handle = slot_is_full ? rd_entry.handle : '0;
                        res_next.buffer_id    = {bumped, slot_reg};
                        wr_en                 = 1'b1;
                        full_next[slot_reg]   = 1'b1;
                        used_next[slot_reg]   = 1'b1;
                    end
                end
                CMD_RETRIEVE, CMD_DISCARD:
                begin
                    if (cur_cookie != req_cookie_reg)
                    begin
                        res_next.status = ST_MISMATCH;
                    end
                    else if (!slot_is_full)
                    begin
                        res_next.status = ST_EMPTY;
                    end
                    else
                    begin
                        full_next[slot_reg] = 1'b0;
                        if (cmd_reg == CMD_RETRIEVE)
                        begin
                            res_next.out_handle = rd_entry.handle;
                            res_next.out_port   = rd_entry.port;
                        end
                        else
                        begin
                            res_next.freed_valid  = 1'b1;
                            res_next.freed_handle = rd_entry.handle;
                        end
                    end
                    if ((cmd_reg == CMD_RETRIEVE) && (res_next.status != ST_OK))
                    begin
                        res_next.out_port = NO_PORT;
                    end
                end
                CMD_NOP:
                begin
                    res_next = '0;
                end
                default:
                begin
                    res_next = '0;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            hold_reg      <= HOLD_RESET;
            next_slot_reg <= '0;
            full_reg      <= '0;
            used_reg      <= '0;
            out_valid_reg <= 1'b0;
            res_reg       <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            next_slot_reg <= next_slot_next;
            full_reg      <= full_next;
            used_reg      <= used_next;
            out_valid_reg <= out_valid_next;
            res_reg       <= res_next;
            if (cfg_valid && cfg_ready)
            begin
                hold_reg <= cfg_data;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cmd_reg        <= cmd_t'(command);
            slot_reg       <= rd_slot;
            req_cookie_reg <= request_id[ID_W-1:SLOT_BITS];
            handle_reg     <= buffer_handle;
            port_reg       <= arrival_port;
            now_reg        <= now_ms;
        end
    end

    assign out_valid    = out_valid_reg;
    assign status       = res_reg.status;
    assign buffer_id    = res_reg.buffer_id;
    assign out_handle   = res_reg.out_handle;
    assign out_port     = res_reg.out_port;
    assign freed_valid  = res_reg.freed_valid;
    assign freed_handle = res_reg.freed_handle;

endmodule

// ===== rtl/core/pbit_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
`timescale 1ns / 1ps

module pbit_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  logic              clk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [WIDTH-1:0]  wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [WIDTH-1:0]  rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// ===== dv/packet_buffer_id_table_tb.sv =====
// Self-checking testbench for the packet buffer id table: random and directed words, scoreboard.
`timescale 1ns / 1ps

module packet_buffer_id_table_tb;
    import pbit_pkg::*;

    typedef enum logic [1:0] {
        PICK_RAW   = 2'd0,
        PICK_LAST  = 2'd1,
        PICK_POOL  = 2'd2,
        PICK_STALE = 2'd3
    } id_pick_t;

    typedef struct packed {
        cmd_t                cmd;
        logic [HANDLE_W-1:0] handle;
        logic [PORT_W-1:0]   port;
        logic [ID_W-1:0]     rid;
        logic [TIME_W-1:0]   now;
        id_pick_t            pick;
    } table_req_t;

    localparam int ISSUED_KEEP  = 48;
    localparam int SETTLE_CYCLES = 4;

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;

    logic                cfg_valid = 1'b0;
    logic                cfg_ready;
    logic [HOLD_W-1:0]   cfg_data = '0;

    logic                in_valid = 1'b0;
    logic                in_stall;
    logic [1:0]          command = '0;
    logic [HANDLE_W-1:0] buffer_handle = '0;
    logic [PORT_W-1:0]   arrival_port = '0;
    logic [ID_W-1:0]     request_id = '0;
    logic [TIME_W-1:0]   now_ms = '0;

    logic                out_valid;
    logic                out_stall = 1'b0;
    logic [1:0]          status;
    logic [ID_W-1:0]     buffer_id;
    logic [HANDLE_W-1:0] out_handle;
    logic [PORT_W-1:0]   out_port;
    logic                freed_valid;
    logic [HANDLE_W-1:0] freed_handle;

    // Shadow copy of the slot ring
    logic [HOLD_W-1:0]    model_hold = HOLD_RESET;
    logic [SLOT_BITS-1:0] model_next = '0;
    logic                 model_full [SLOT_COUNT] = '{default: 1'b0};
    logic [COOKIE_W-1:0]  model_cookie [SLOT_COUNT] = '{default: '0};
    logic [TIME_W-1:0]    model_deadline [SLOT_COUNT];
    logic [HANDLE_W-1:0]  model_handle [SLOT_COUNT];
    logic [PORT_W-1:0]    model_port [SLOT_COUNT];

    table_req_t          request_backlog [$];
    result_t             expected_replies [$];
    logic [ID_W-1:0]     issued_ids [$];
    table_req_t          cur_req;
    logic [TIME_W-1:0]   clock_ms = '0;
    int unsigned         words_queued = 0;
    int unsigned         words_accepted = 0;
    int unsigned         failures = 0;

    logic                quiet = 1'b0;
    logic                squeeze_phase = 1'b0;
    logic                squeeze_done = 1'b0;
    logic [7:0]          squeeze_left = '0;

    packet_buffer_id_table u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .command      (command),
        .buffer_handle(buffer_handle),
        .arrival_port (arrival_port),
        .request_id   (request_id),
        .now_ms       (now_ms),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .status       (status),
        .buffer_id    (buffer_id),
        .out_handle   (out_handle),
        .out_port     (out_port),
        .freed_valid  (freed_valid),
        .freed_handle (freed_handle)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Expected reply of one accepted word; updates the shadow ring.
    function automatic result_t apply_request(input table_req_t r);
        result_t              rep;
        logic [SLOT_BITS-1:0] s;
        logic [COOKIE_W-1:0]  c;
        logic [TIME_W:0]      dl;
        rep = '0;
        case (r.cmd)
            CMD_SAVE:
            begin
                s = model_next;
                model_next = s + 1'b1;
                if (model_full[s] && r.now < model_deadline[s])
                begin
                    rep.status = ST_BUSY;
                    rep.buffer_id = REFUSED_ID;
                end
                else
                begin
                    if (model_full[s])
                    begin
                        rep.freed_valid = 1'b1;
                        rep.freed_handle = model_handle[s];
                    end
                    // skip the all-ones cookie so that value never matches
                    c = model_cookie[s] + 1'b1;
                    if (c == COOKIE_LAST)
                        c = '0;
                    model_cookie[s] = c;
                    model_full[s] = 1'b1;
                    model_handle[s] = r.handle;
                    model_port[s] = r.port;
                    dl = {1'b0, r.now} + model_hold;
                    model_deadline[s] = dl[TIME_W] ? TIME_MAX : dl[TIME_W-1:0];
                    rep.buffer_id = {c, s};
                    issued_ids.push_back({c, s});
                    if (issued_ids.size() > ISSUED_KEEP)
                        void'(issued_ids.pop_front());
                end
            end
            CMD_RETRIEVE, CMD_DISCARD:
            begin
                s = r.rid[SLOT_BITS-1:0];
                c = r.rid[ID_W-1:SLOT_BITS];
                if (model_cookie[s] != c)
                    rep.status = ST_MISMATCH;
                else if (!model_full[s])
                    rep.status = ST_EMPTY;
                else
                begin
                    model_full[s] = 1'b0;
                    if (r.cmd == CMD_RETRIEVE)
                    begin
                        rep.out_handle = model_handle[s];
                        rep.out_port = model_port[s];
                    end
                    else
                    begin
                        rep.freed_valid = 1'b1;
                        rep.freed_handle = model_handle[s];
                    end
                end
                if (r.cmd == CMD_RETRIEVE && rep.status != ST_OK)
                    rep.out_port = NO_PORT;
            end
            default:
            begin
            end
        endcase
        return rep;
    endfunction

    // Fill in the id from recently issued ids at the moment the word is loaded.
    function automatic table_req_t resolve_id(input table_req_t r);
        logic [ID_W-1:0] id;
        if (r.pick != PICK_RAW && issued_ids.size() != 0)
        begin
            if (r.pick == PICK_LAST)
                id = issued_ids[issued_ids.size()-1];
            else
                id = issued_ids[$urandom_range(issued_ids.size()-1)];
            if (r.pick == PICK_STALE)
                id[ID_W-1:SLOT_BITS] = $urandom_range(1) ? id[ID_W-1:SLOT_BITS] + 1'b1
                                                         : id[ID_W-1:SLOT_BITS] - 1'b1;
            r.rid = id;
        end
        return r;
    endfunction

    function automatic table_req_t make_req(input cmd_t cmd, input logic [HANDLE_W-1:0] handle,
                                            input logic [PORT_W-1:0] port,
                                            input logic [ID_W-1:0] rid,
                                            input logic [TIME_W-1:0] now, input id_pick_t pick);
        table_req_t r;
        r.cmd = cmd;
        r.handle = handle;
        r.port = port;
        r.rid = rid;
        r.now = now;
        r.pick = pick;
        return r;
    endfunction

    // Mostly well-formed traffic on a forward-running clock, some noise.
    function automatic table_req_t random_request(input int unsigned step_max);
        table_req_t  r;
        int unsigned roll;
        roll = $urandom_range(99);
        clock_ms += $urandom_range(step_max);
        if ($urandom_range(49) == 0)
            clock_ms += TIME_W'(step_max) * 300;
        r = make_req(CMD_SAVE, $urandom, PORT_W'($urandom), $urandom, clock_ms, PICK_RAW);
        if (roll < 45)
            r.cmd = CMD_SAVE;
        else if (roll < 65)
        begin
            r.cmd = CMD_RETRIEVE;
            r.pick = PICK_POOL;
        end
        else if (roll < 77)
        begin
            r.cmd = CMD_DISCARD;
            r.pick = PICK_POOL;
        end
        else if (roll < 85)
        begin
            r.cmd = roll[0] ? CMD_RETRIEVE : CMD_DISCARD;
            r.pick = PICK_STALE;
        end
        else if (roll < 90)
        begin
            r.cmd = CMD_RETRIEVE;
            r.pick = PICK_LAST;
        end
        else
        begin
            r.cmd = cmd_t'($urandom_range(3));
            if (roll[0])
                r.now = {PORT_W'($urandom), 32'($urandom)};
        end
        return r;
    endfunction

    task automatic queue_request(input table_req_t r);
        request_backlog.push_back(r);
        words_queued++;
    endtask

    // Hold until every queued word is taken and every reply has come back.
    task automatic drain_all();
        while (words_accepted != words_queued || expected_replies.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_hold(input logic [HOLD_W-1:0] value);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        model_hold = value;
    endtask

    task automatic check_field(input string name, input logic [63:0] want,
                               input logic [63:0] got);
        if (got !== want)
        begin
            $error("%s: expected 'h%0h, got 'h%0h", name, want, got);
            failures++;
        end
    endtask

    // Driver: predict the word taken at this edge, then load the next one.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && !in_stall)
            begin
                expected_replies.push_back(apply_request(cur_req));
                words_accepted++;
            end
            if (!in_valid || !in_stall)
            begin
                if (request_backlog.size() != 0 && (quiet || $urandom_range(99) >= 8))
                begin
                    cur_req = resolve_id(request_backlog.pop_front());
                    in_valid <= 1'b1;
                    command <= cur_req.cmd;
                    buffer_handle <= cur_req.handle;
                    arrival_port <= cur_req.port;
                    request_id <= cur_req.rid;
                    now_ms <= cur_req.now;
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // Receiver back-pressure, with one long hold-off during the squeeze phase.
    always @(posedge clk)
    begin
        if (!rst_n)
            out_stall <= 1'b0;
        else if (squeeze_left != 0)
        begin
            out_stall <= 1'b1;
            squeeze_left <= squeeze_left - 1'b1;
        end
        else if (squeeze_phase && !squeeze_done)
        begin
            out_stall <= 1'b1;
            squeeze_left <= 8'd150;
            squeeze_done <= 1'b1;
        end
        else
            out_stall <= !quiet && ($urandom_range(99) < 8);
    end

    // Monitor
    always @(posedge clk)
    begin
        result_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_replies.size() == 0)
            begin
                $error("reply with no word outstanding: buffer_id 'h%0h", buffer_id);
                failures++;
            end
            else
            begin
                want = expected_replies.pop_front();
                check_field("status", want.status, status);
                check_field("buffer_id", want.buffer_id, buffer_id);
                check_field("out_handle", want.out_handle, out_handle);
                check_field("out_port", want.out_port, out_port);
                check_field("freed_valid", want.freed_valid, freed_valid);
                check_field("freed_handle", want.freed_handle, freed_handle);
            end
        end
    end

    initial
    begin
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
    end

    initial
    begin
        #5000000;
        $display("*** FAILED ***");
        $finish;
    end

    initial
    begin
        logic [HOLD_W-1:0] phase_hold [6];
        phase_hold = '{HOLD_W'(3000), HOLD_W'(0), '1, HOLD_W'($urandom), HOLD_W'(1),
                       HOLD_W'(250)};
        wait (rst_n);
        @(posedge clk);

        // directed: all commands, field extremes, empty and mismatch paths
        queue_request(make_req(CMD_SAVE, '0, '0, '0, '0, PICK_RAW));
        queue_request(make_req(CMD_RETRIEVE, '0, '0, '0, '0, PICK_LAST));
        queue_request(make_req(CMD_RETRIEVE, '0, '0, '0, '0, PICK_LAST));
        queue_request(make_req(CMD_SAVE, '1, '1, '0, TIME_W'(10), PICK_RAW));
        queue_request(make_req(CMD_DISCARD, '0, '0, '0, '0, PICK_STALE));
        queue_request(make_req(CMD_RETRIEVE, '0, '0, '1, TIME_W'(12), PICK_RAW));
        queue_request(make_req(CMD_DISCARD, '0, '0, '0, '0, PICK_LAST));
        queue_request(make_req(CMD_DISCARD, '0, '0, '0, '0, PICK_LAST));
        queue_request(make_req(CMD_SAVE, $urandom, PORT_W'($urandom), '0, TIME_W'(20),
                               PICK_RAW));
        queue_request(make_req(CMD_NOP, '1, '1, '1, '1, PICK_RAW));
        queue_request(make_req(CMD_NOP, '0, '0, '0, '0, PICK_RAW));
        queue_request(make_req(CMD_RETRIEVE, '0, '0, {24'd0, 8'd200}, '0, PICK_RAW));
        queue_request(make_req(CMD_DISCARD, '0, '0, {24'd5, 8'd3}, '0, PICK_RAW));
        drain_all();

        // deadline saturation at the top of the time range
        write_hold('1);
        queue_request(make_req(CMD_SAVE, $urandom, '1, '0, TIME_MAX - 10, PICK_RAW));
        queue_request(make_req(CMD_SAVE, $urandom, '0, '0, TIME_MAX, PICK_RAW));
        queue_request(make_req(CMD_SAVE, $urandom, '1, '0, TIME_MAX - 65535, PICK_RAW));
        queue_request(make_req(CMD_RETRIEVE, '0, '0, '0, TIME_MAX, PICK_LAST));
        drain_all();

        for (int p = 0; p < 6; p++)
        begin
            write_hold(phase_hold[p]);
            quiet <= (p == 1);
            squeeze_phase <= (p == 2);
            for (int n = 0; n < 285; n++)
                queue_request(random_request(phase_hold[p] / 150 + 2));
            // sender pauses here until every reply is back
            drain_all();
        end

        if (expected_replies.size() != 0)
            failures++;
        if (failures == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
